// ===== hw/rtl/type_length_packet_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Type-length packet deframer assertion macros
// Implication checks clocked on a rising edge, off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TYPE_LENGTH_PACKET_DEFRAMER_MACROS_SVH
`define TYPE_LENGTH_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication
`define TLPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tlpd same-cycle check failed");

// next-cycle implication
`define TLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tlpd next-cycle check failed");

`endif

// ===== hw/rtl/tlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Type-length packet deframer package
// Item and result types, opcodes and error codes shared by the stages.
// ----------------------------------------------------------------------------
package tlpd_pkg;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_ABORT = 1'b1;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_LENGTH = 2'd1;
	localparam logic [1:0] ERR_ABORT  = 2'd2;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} step_t;

	typedef struct packed {
		logic [7:0] packet_type;
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       last;
		logic [1:0] error_code;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} res_beat_t;

endpackage

// ===== hw/rtl/type_length_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// Type-length packet deframer
// Splits a byte stream into type/length headed packets, one byte per item.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------------
//   item    | item_valid / item_stall     | opcode, data_byte
//   result  | result_valid / result_stall | packet_type, payload_byte,
//           |                             | has_byte, last, error_code
//
// One item per cycle while item_stall is low; an item goes through the input
// register, the single parse step and the result register to its result.
// Reset returns to header hunting with no item or result held.
// A stalled result holds; one more item waits in the input register, then
// item_stall rises.
// ----------------------------------------------------------------------------
module type_length_packet_deframer #(
	parameter int HEADER_BYTES = 5,
	parameter int LENGTH_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       opcode,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] packet_type,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       last,
	output logic [1:0] error_code
);

	tlpd_pkg::item_t     item_in;
	tlpd_pkg::step_t     step;
	tlpd_pkg::res_beat_t res;
	tlpd_pkg::result_t   result;
	logic                slot_free;

	assign item_in.opcode    = opcode;
	assign item_in.data_byte = data_byte;

	tlpd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_in    (item_in),
		.slot_free  (slot_free),
		.step       (step)
	);

	tlpd_parser #(
		.HEADER_BYTES (HEADER_BYTES),
		.LENGTH_BYTES (LENGTH_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.res    (res)
	);

	tlpd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.slot_free    (slot_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign packet_type  = result.packet_type;
	assign payload_byte = result.payload_byte;
	assign has_byte     = result.has_byte;
	assign last         = result.last;
	assign error_code   = result.error_code;

endmodule

// ===== hw/rtl/tlpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Type-length packet deframer input stage
// Registers one item and holds it until the parser advances.
// ----------------------------------------------------------------------------
module tlpd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  tlpd_pkg::item_t item_in,
	input  logic           slot_free,
	output tlpd_pkg::step_t step
);

	logic            valid_s1;
	tlpd_pkg::item_t item_s1;
	logic            advance;
	logic            load;

	assign advance    = valid_s1 & slot_free;
	assign item_stall = valid_s1 & ~advance;
	assign load       = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

	assign step.valid = advance;
	assign step.item  = item_s1;

endmodule

// ===== hw/rtl/tlpd_parser.sv =====
// ----------------------------------------------------------------------------
// Type-length packet deframer parser
// Header counter, length and type capture, payload countdown, result build.
// ----------------------------------------------------------------------------
`include "type_length_packet_deframer_macros.svh"

module tlpd_parser #(
	parameter int HEADER_BYTES = 5,
	parameter int LENGTH_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlpd_pkg::step_t      step,
	output tlpd_pkg::res_beat_t  res
);

	localparam int HCW = $clog2(HEADER_BYTES + 1);
	localparam logic [HCW-1:0] HC_FULL = HCW'(HEADER_BYTES);
	localparam logic [HCW-1:0] HC_ONE  = HCW'(1);

	logic [HCW-1:0] hc_q, hc_d, hc_inc;
	logic [31:0]    len_q, len_d;
	logic [7:0]     type_q, type_d;
	logic [30:0]    rem_q, rem_d;

	always_comb begin
		hc_d     = hc_q;
		len_d    = len_q;
		type_d   = type_q;
		rem_d    = rem_q;
		hc_inc   = hc_q + HC_ONE;
		res      = '0;
		res.data.packet_type = type_q;
		if (step.valid) begin
			if (step.item.opcode == tlpd_pkg::OP_ABORT) begin
				if (hc_q != '0) begin
					hc_d                = '0;
					rem_d               = '0;
					res.valid           = 1'b1;
					res.data.last       = 1'b1;
					res.data.error_code = tlpd_pkg::ERR_ABORT;
				end
			end else if (hc_q >= HC_FULL) begin
				if (rem_q == '0) begin
					hc_d = '0;
				end else begin
					rem_d                 = rem_q - 31'd1;
					res.valid             = 1'b1;
					res.data.has_byte     = 1'b1;
					res.data.payload_byte = step.item.data_byte;
					if (rem_q == 31'd1) begin
						res.data.last = 1'b1;
						hc_d          = '0;
					end
				end
			end else begin
				if (hc_q == '0) begin
					type_d = step.item.data_byte;
					len_d  = '0;
				end else begin
					for (int i = 0; i < 4; i++) begin
						if (i < LENGTH_BYTES && int'(hc_q) == i + 1) begin
							len_d[8*i +: 8] = step.item.data_byte;
						end
					end
				end
				hc_d = hc_inc;
				if (hc_inc == HC_FULL) begin
					res.data.packet_type = type_d;
					if (len_d[31]) begin
						hc_d                = '0;
						rem_d               = '0;
						res.valid           = 1'b1;
						res.data.last       = 1'b1;
						res.data.error_code = tlpd_pkg::ERR_LENGTH;
					end else if (len_d == '0) begin
						hc_d          = '0;
						rem_d         = '0;
						res.valid     = 1'b1;
						res.data.last = 1'b1;
					end else begin
						rem_d = len_d[30:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q   <= '0;
			len_q  <= '0;
			type_q <= '0;
			rem_q  <= '0;
		end else begin
			hc_q   <= hc_d;
			len_q  <= len_d;
			type_q <= type_d;
			rem_q  <= rem_d;
		end
	end

	`TLPD_ASSERT_NOW(a_payload_has_count, clk, arst_n, hc_q == HC_FULL, rem_q != '0)
	`TLPD_ASSERT_NEXT(a_last_rehunts, clk, arst_n, res.valid && res.data.last, hc_q == '0)
	`TLPD_ASSERT_NOW(a_error_no_byte, clk, arst_n, res.valid && res.data.error_code != tlpd_pkg::ERR_OK, !res.data.has_byte && res.data.last)

endmodule

// ===== hw/rtl/tlpd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Type-length packet deframer output stage
// Result register; frees its slot when the result is taken.
// ----------------------------------------------------------------------------
module tlpd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  tlpd_pkg::res_beat_t res,
	output logic                slot_free,
	output logic                result_valid,
	input  logic                result_stall,
	output tlpd_pkg::result_t   result
);

	logic              valid_q;
	tlpd_pkg::result_t data_q;
	logic              take;

	assign take      = valid_q & ~result_stall;
	assign slot_free = ~valid_q | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= res.valid | (valid_q & ~take);
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			data_q <= res.data;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule
